FILE: sv/text_console_writer_with_scroll_top_defines.svh
// Assertion macros for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_WITH_SCROLL_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_WITH_SCROLL_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define TCWS_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("tcws: invariant violated");

`define TCWS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tcws: same-cycle implication violated");

`define TCWS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tcws: next-cycle implication violated");

`else

`define TCWS_ASSERT_ALWAYS(label, clk, rstn, cond)
`define TCWS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define TCWS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: sv/tcws_pkg.sv
// Types and constants of the text console writer.
`default_nettype none

package tcws_pkg;

    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0] BLANK_ATTR   = 8'h0F;
    localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h0F;

    typedef struct packed {
        logic                   cmd;
        logic [CHAR_W-1:0]      char_code;
        logic [ROW_FIELD_W-1:0] read_row;
        logic [COL_FIELD_W-1:0] read_col;
    } in_word_t;

    typedef struct packed {
        logic [CELL_W-1:0]      cell_value;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_col;
    } out_word_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

FILE: sv/text_console_writer_with_scroll_top.sv
// Text-mode screen buffer with cursor, newline wrap and scroll.
//
// A put word's result is written straight into the output register; a read word
// first passes the registered reads of the cell memory and the row-info memory.
// A new word is taken once the previous result has left or is leaving the output
// register. Scrolling moves a circular row-base pointer instead of copying
// cells. Each physical row carries a fill count and a fill attribute in a small
// row-info memory: cells at or beyond the count read as spaces in that attribute,
// so reset and scrolling blank a row at once and no clearing pass runs after reset.
`default_nettype none
`include "text_console_writer_with_scroll_top_defines.svh"

module text_console_writer_with_scroll_top
    import tcws_pkg::*;
#(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_word_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_word_t              m_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [CHAR_W-1:0] cfg_wr_data
);

    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int CW    = $clog2(SCREEN_COLS + 1);
    localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int MW    = CW + CHAR_W;

    localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
    localparam logic [CW-1:0] FULL_COL = CW'(SCREEN_COLS);

    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                               input logic [RW-1:0] base);
        logic [RW:0] sum;
        sum = {1'b0, lrow} + {1'b0, base};
        if (sum >= (RW+1)'(SCREEN_ROWS)) begin
            sum = sum - (RW+1)'(SCREEN_ROWS);
        end
        return sum[RW-1:0];
    endfunction

    logic [CELL_W-1:0] cell_mem [CELLS];
    logic [MW-1:0]     meta_mem [SCREEN_ROWS];

    state_t                  state_reg, state_next;
    logic [RW-1:0]           line_reg, line_next;
    logic [CW-1:0]           col_reg, col_next;
    logic [RW-1:0]           base_reg, base_next;
    logic [CHAR_W-1:0]       fill_attr_reg, fill_attr_next;
    logic [CHAR_W-1:0]       attr_reg;
    logic [SCREEN_ROWS-1:0]  row_valid_reg, row_valid_next;
    logic                    m_valid_reg, m_valid_next;
    out_word_t               m_data_reg, m_data_next;

    logic [CELL_W-1:0]       cell_rdata_reg;
    logic [MW-1:0]           meta_rdata_reg;
    logic                    rd_valid_reg;
    logic [CW-1:0]           rd_col_reg;
    logic                    rd_in_range_reg;

    logic                    accept;
    logic                    wrap, at_last, scroll, is_char;
    logic [RW-1:0]           base_put, line_put, wrow;
    logic [CW-1:0]           col_wrap, col_put;
    logic [CHAR_W-1:0]       attr_put;
    logic                    rd_in_range;
    logic [RW-1:0]           rrow, rphys;
    logic [CW-1:0]           rcol;
    logic [AW-1:0]           cell_raddr, cell_waddr;
    logic                    cell_we, meta_we;
    logic [CELL_W-1:0]       cell_wdata;
    logic [MW-1:0]           meta_wdata;
    logic [CW-1:0]           rd_count;
    logic [CHAR_W-1:0]       rd_attr;
    logic [CELL_W-1:0]       rd_value;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // put path
    assign is_char  = (s_data.char_code != NEWLINE_CODE);
    assign wrap     = !is_char || (col_reg == FULL_COL);
    assign at_last  = (line_reg == LAST_ROW);
    assign scroll   = wrap && at_last;
    assign base_put = !scroll ? base_reg : ((base_reg == LAST_ROW) ? '0 : base_reg + 1'b1);
    assign line_put = (wrap && !at_last) ? line_reg + 1'b1 : line_reg;
    assign col_wrap = wrap ? '0 : col_reg;
    assign col_put  = is_char ? col_wrap + 1'b1 : col_wrap;
    assign attr_put = scroll ? attr_reg : (wrap ? BLANK_ATTR : fill_attr_reg);
    assign wrow     = phys_row(line_put, base_put);

    assign cell_waddr = AW'(wrow) * AW'(SCREEN_COLS) + AW'(col_wrap);
    assign cell_wdata = {attr_reg, s_data.char_code};
    assign meta_wdata = {col_put, attr_put};

    // read path
    assign rd_in_range = (int'(s_data.read_row) < SCREEN_ROWS)
                      && (int'(s_data.read_col) < SCREEN_COLS);
    assign rrow       = rd_in_range ? RW'(s_data.read_row) : '0;
    assign rcol       = rd_in_range ? CW'(s_data.read_col) : '0;
    assign rphys      = phys_row(rrow, base_reg);
    assign cell_raddr = AW'(rphys) * AW'(SCREEN_COLS) + AW'(rcol);

    assign rd_count = rd_valid_reg ? meta_rdata_reg[MW-1:CHAR_W] : '0;
    assign rd_attr  = rd_valid_reg ? meta_rdata_reg[CHAR_W-1:0] : BLANK_ATTR;
    assign rd_value = !rd_in_range_reg ? '0
                    : ((rd_col_reg < rd_count) ? cell_rdata_reg : {rd_attr, SPACE_CODE});

    always_ff @(posedge aclk) begin
        if (cell_we) begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        cell_rdata_reg <= cell_mem[cell_raddr];
    end

    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[wrow] <= meta_wdata;
        end
        meta_rdata_reg <= meta_mem[rphys];
    end

    always_ff @(posedge aclk) begin
        rd_valid_reg    <= row_valid_reg[rphys];
        rd_col_reg      <= rcol;
        rd_in_range_reg <= rd_in_range;
        m_data_reg      <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            line_reg      <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            fill_attr_reg <= RESET_ATTR;
            attr_reg      <= RESET_ATTR;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            fill_attr_reg <= fill_attr_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        fill_attr_next = fill_attr_reg;
        row_valid_next = row_valid_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        cell_we        = 1'b0;
        meta_we        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.cmd == CMD_READ) begin
                        state_next = ST_READ;
                    end else begin
                        line_next      = line_put;
                        col_next       = col_put;
                        base_next      = base_put;
                        fill_attr_next = attr_put;
                        cell_we        = is_char;
                        meta_we        = is_char || scroll;
                        if (is_char || scroll) begin
                            row_valid_next[wrow] = 1'b1;
                        end
                        m_valid_next           = 1'b1;
                        m_data_next.cell_value = is_char ? cell_wdata : '0;
                        m_data_next.cursor_row = ROW_FIELD_W'(line_put);
                        m_data_next.cursor_col = COL_FIELD_W'(col_put);
                    end
                end
            end
            ST_READ: begin
                state_next             = ST_IDLE;
                m_valid_next           = 1'b1;
                m_data_next.cell_value = rd_value;
                m_data_next.cursor_row = ROW_FIELD_W'(line_reg);
                m_data_next.cursor_col = COL_FIELD_W'(col_reg);
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `TCWS_ASSERT_ALWAYS(a_col_bound, aclk, aresetn, col_reg <= FULL_COL)
    `TCWS_ASSERT_ALWAYS(a_base_bound, aclk, aresetn, base_reg <= LAST_ROW)
    `TCWS_ASSERT_IMPL(a_base_before_scroll, aclk, aresetn, line_reg != LAST_ROW, base_reg == '0)
    `TCWS_ASSERT_NEXT(a_read_wait, aclk, aresetn, accept && s_data.cmd == CMD_READ, state_reg == ST_READ && !m_valid_reg)
    `TCWS_ASSERT_NEXT(a_put_result, aclk, aresetn, accept && s_data.cmd == CMD_PUT, m_valid_reg && state_reg == ST_IDLE)

endmodule

`default_nettype wire

FILE: bench/text_console_writer_with_scroll_top_tb.sv
// Testbench for the text console writer: directed and random puts, reads and scrolling.
`default_nettype none

module text_console_writer_with_scroll_top_tb
    import tcws_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_COLS    = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLS * SCREEN_ROWS;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int MAX_PRINTED    = 40;
    localparam int IN_W           = $bits(in_word_t);

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    in_word_t  s_data      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    out_word_t m_data;
    logic      cfg_wr_en   = 1'b0;
    logic [CHAR_W-1:0] cfg_wr_data = '0;

    logic [CELL_W-1:0] screen_model [0:CELL_COUNT-1];
    int                cursor_row_model;
    int                cursor_col_model;
    logic [CHAR_W-1:0] attr_model;

    out_word_t replies_due [$];

    bit quiet_sender   = 1'b0;
    bit quiet_receiver = 1'b0;
    bit hold_off_req   = 1'b0;

    int mismatch_count  = 0;
    int words_sent      = 0;
    int reads_sent      = 0;
    int replies_checked = 0;
    int scroll_count    = 0;
    int attr_writes     = 0;
    int hold_offs_done  = 0;
    int idle_cycles     = 0;

    text_console_writer_with_scroll_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic out_word_t console_reply(input in_word_t w);
        out_word_t r;
        int        idx;
        r = '0;
        if (w.cmd == CMD_READ) begin
            if (int'(w.read_row) < SCREEN_ROWS && int'(w.read_col) < SCREEN_COLS) begin
                r.cell_value = screen_model[int'(w.read_row) * SCREEN_COLS + int'(w.read_col)];
            end
        end else begin
            if (w.char_code == NEWLINE_CODE || cursor_col_model >= SCREEN_COLS) begin
                cursor_col_model = 0;
                cursor_row_model++;
            end
            if (cursor_row_model >= SCREEN_ROWS) begin
                for (idx = 0; idx < (SCREEN_ROWS - 1) * SCREEN_COLS; idx++) begin
                    screen_model[idx] = screen_model[idx + SCREEN_COLS];
                end
                for (idx = (SCREEN_ROWS - 1) * SCREEN_COLS; idx < CELL_COUNT; idx++) begin
                    screen_model[idx] = {attr_model, SPACE_CODE};
                end
                cursor_row_model = SCREEN_ROWS - 1;
                scroll_count++;
            end
            if (w.char_code != NEWLINE_CODE) begin
                r.cell_value = {attr_model, w.char_code};
                screen_model[cursor_row_model * SCREEN_COLS + cursor_col_model] = r.cell_value;
                cursor_col_model++;
            end
        end
        r.cursor_row = cursor_row_model[ROW_FIELD_W-1:0];
        r.cursor_col = cursor_col_model[COL_FIELD_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("mismatch %s: got 0x%0h, want 0x%0h (reply %0d)",
                     what, got, want, replies_checked);
        end
    endtask

    task automatic send_word(input in_word_t w);
        int gap;
        gap = pick_gap(quiet_sender);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        replies_due.push_back(console_reply(w));
        words_sent++;
        if (w.cmd == CMD_READ) reads_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_attribute(input logic [CHAR_W-1:0] value);
        wait_drained();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        attr_model = value;
        attr_writes++;
    endtask

    function automatic in_word_t put_word(input logic [CHAR_W-1:0] ch);
        in_word_t w;
        w.cmd       = CMD_PUT;
        w.char_code = ch;
        w.read_row  = ROW_FIELD_W'($urandom_range(0, 31));
        w.read_col  = COL_FIELD_W'($urandom_range(0, 127));
        return w;
    endfunction

    function automatic in_word_t read_word(input int row, input int col);
        in_word_t w;
        w.cmd       = CMD_READ;
        w.char_code = CHAR_W'($urandom_range(0, 255));
        w.read_row  = row[ROW_FIELD_W-1:0];
        w.read_col  = col[COL_FIELD_W-1:0];
        return w;
    endfunction

    function automatic in_word_t random_read();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return read_word(cursor_row_model, $urandom_range(0, SCREEN_COLS - 1));
        if (r < 80) return read_word($urandom_range(0, SCREEN_ROWS - 1),
                                     $urandom_range(0, SCREEN_COLS - 1));
        return read_word($urandom_range(0, 31), $urandom_range(0, 127));
    endfunction

    task automatic test_blank_screen();
        send_word(read_word(0, 0));
        send_word(read_word(SCREEN_ROWS - 1, SCREEN_COLS - 1));
        send_word(read_word(12, 40));
        send_word(read_word(SCREEN_ROWS, 0));
        send_word(read_word(0, SCREEN_COLS));
        send_word(read_word(31, 127));
    endtask

    task automatic test_directed_puts();
        send_word(put_word(8'h00));
        send_word(put_word(8'hFF));
        send_word(put_word(8'h08));
        send_word(put_word(NEWLINE_CODE));
        send_word(put_word(NEWLINE_CODE));
        send_word(read_word(0, 0));
        send_word(read_word(0, 1));
        send_word(read_word(0, 2));
        send_word(read_word(0, 3));
        set_attribute(8'hFF);
        send_word(put_word(8'h41));
        send_word(read_word(0, 0));
        send_word(read_word(2, 0));
        send_word(read_word(2, 1));
        set_attribute(8'h00);
        send_word(put_word(8'h7F));
        send_word(read_word(2, 1));
    endtask

    // lines of random text with reads and random words mixed in; long lines run past the edge and wrap
    task automatic test_text_lines(input int n_words);
        int goal;
        int len;
        int r;
        int i;
        in_word_t w;
        goal = words_sent + n_words;
        while (words_sent < goal) begin
            r = $urandom_range(0, 99);
            if (r < 60) len = $urandom_range(0, 20);
            else if (r < 85) len = $urandom_range(21, SCREEN_COLS - 1);
            else len = $urandom_range(SCREEN_COLS, SCREEN_COLS + 4);
            for (i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                if (r < 20) begin
                    send_word(random_read());
                end else if (r < 24) begin
                    w = IN_W'($urandom);
                    send_word(w);
                end
                send_word(put_word(CHAR_W'($urandom_range(0, 255))));
            end
            if ($urandom_range(0, 9) < 8) send_word(put_word(NEWLINE_CODE));
            if ($urandom_range(0, 3) == 0) send_word(random_read());
        end
    endtask

    task automatic test_backpressure();
        quiet_sender = 1'b1;
        hold_off_req = 1'b1;
        test_text_lines(60);
        quiet_sender = 1'b0;
        wait_drained();
        test_text_lines(100);
    endtask

    task automatic test_steady_stream();
        quiet_sender   = 1'b1;
        quiet_receiver = 1'b1;
        test_text_lines(300);
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    initial begin : receiver
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_offs_done++;
            end else if (!quiet_receiver && $urandom_range(0, 3) == 0) begin
                n = 1 + pick_gap(1'b0);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : reply_check
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                report_mismatch("unexpected reply", int'(m_data), 0);
            end else begin
                want = replies_due.pop_front();
                if (m_data.cell_value !== want.cell_value)
                    report_mismatch("cell_value", int'(m_data.cell_value),
                                    int'(want.cell_value));
                if (m_data.cursor_row !== want.cursor_row)
                    report_mismatch("cursor_row", int'(m_data.cursor_row),
                                    int'(want.cursor_row));
                if (m_data.cursor_col !== want.cursor_col)
                    report_mismatch("cursor_col", int'(m_data.cursor_col),
                                    int'(want.cursor_col));
            end
            replies_checked++;
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("stalled for %0d cycles with %0d replies due",
                         idle_cycles, replies_due.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {BLANK_ATTR, SPACE_CODE};
        cursor_row_model = 0;
        cursor_col_model = 0;
        attr_model       = RESET_ATTR;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_blank_screen();
        test_directed_puts();
        test_text_lines(450);
        set_attribute(8'($urandom_range(1, 254)));
        test_backpressure();
        set_attribute(8'($urandom_range(1, 254)));
        test_steady_stream();
        set_attribute(8'hFF);
        test_text_lines(450);
        set_attribute(RESET_ATTR);
        test_text_lines(400);
        wait_drained();

        $display("sent %0d words (%0d reads), checked %0d replies, %0d mismatches",
                 words_sent, reads_sent, replies_checked, mismatch_count);
        $display("model scrolled %0d times over %0d attribute writes, %0d long output stalls",
                 scroll_count, attr_writes, hold_offs_done);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
